@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/qqdot_pkg.sv @@
// Shared constants, types and command/status structs for the q4 x q8 block dot unit.
// No dependencies.
package qqdot_pkg;
	localparam int LANES = 8;
	localparam int NIB_W = 4;
	localparam int ACT_W = 8;
	localparam int PROD_W = NIB_W + ACT_W;
	localparam int ITEM_W = PROD_W + $clog2(LANES);
	localparam int BSUM_W = 17;
	localparam int HALF_W = 16;
	localparam int IN_W = 128;
	localparam int OUT_W = 32;
	localparam int EXP_W = 12;
	localparam int MAN_W = 64;
	localparam int NIB_OFS = 0;
	localparam int ACT_OFS = 32;
	localparam int WSC_OFS = 96;
	localparam int ASC_OFS = 112;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS = 32'h7F80_0000;

	localparam logic [1:0] NORM_TERM = 2'd0;
	localparam logic [1:0] NORM_ACC = 2'd1;
	localparam logic [1:0] NORM_SUM = 2'd2;

	typedef struct packed {
		logic item_take;
		logic blk_end;
		logic mul1;
		logic mul2;
		logic norm_en;
		logic [1:0] norm_sel;
		logic align;
		logic rnd;
		logic fin;
	} qqdot_cmd_t;

	typedef struct packed {
		logic spec;
		logic norm_done;
		logic row_end;
		logic out_busy;
	} qqdot_sts_t;
endpackage

@@ rtl/qqdot_ctrl.sv @@
// Controller: item counting and sequencing of the fp32 accumulator update.
// Depends on qqdot_pkg.
module qqdot_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	output qqdot_pkg::qqdot_cmd_t cmd,
	input qqdot_pkg::qqdot_sts_t sts
);
	import qqdot_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_MUL2 = 4'd2;
	localparam logic [3:0] ST_NORMT = 4'd3;
	localparam logic [3:0] ST_NORMA = 4'd4;
	localparam logic [3:0] ST_ALIGN = 4'd5;
	localparam logic [3:0] ST_NORMS = 4'd6;
	localparam logic [3:0] ST_ROUND = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] quarter_q;
	logic take;
	logic fin_go;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign take = s_axis_tvalid && (state_q == ST_IDLE);
	assign fin_go = (state_q == ST_FIN) && !(sts.row_end && sts.out_busy);

	always_comb begin
		cmd = '0;
		cmd.item_take = take;
		cmd.blk_end = take && (quarter_q == 2'd3);
		cmd.mul1 = (state_q == ST_MUL1);
		cmd.mul2 = (state_q == ST_MUL2);
		cmd.align = (state_q == ST_ALIGN);
		cmd.rnd = (state_q == ST_ROUND);
		cmd.fin = fin_go;
		cmd.norm_en = (state_q == ST_NORMT) || (state_q == ST_NORMA) || (state_q == ST_NORMS);
		cmd.norm_sel = (state_q == ST_NORMA) ? NORM_ACC :
			(state_q == ST_NORMS) ? NORM_SUM : NORM_TERM;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && (quarter_q == 2'd3)) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = sts.spec ? ST_FIN : ST_MUL2;
			ST_MUL2: state_d = ST_NORMT;
			ST_NORMT: begin
				if (sts.norm_done) state_d = ST_NORMA;
			end
			ST_NORMA: begin
				if (sts.norm_done) state_d = ST_ALIGN;
			end
			ST_ALIGN: state_d = ST_NORMS;
			ST_NORMS: begin
				if (sts.norm_done) state_d = ST_ROUND;
			end
			ST_ROUND: state_d = ST_FIN;
			ST_FIN: begin
				if (fin_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quarter_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) quarter_q <= quarter_q + 2'd1;
		end
	end
endmodule

@@ rtl/qqdot_dp.sv @@
// Datapath: integer lanes, block sum, scale product, shared normalizer, align/add,
// rounding, fp32 accumulator and output register. Depends on qqdot_pkg.
module qqdot_dp (
	input logic clk,
	input logic arst_n,
	input logic [qqdot_pkg::IN_W-1:0] s_axis_tdata,
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [qqdot_pkg::OUT_W-1:0] m_axis_tdata,
	input qqdot_pkg::qqdot_cmd_t cmd,
	output qqdot_pkg::qqdot_sts_t sts
);
	import qqdot_pkg::*;

	// integer lanes
	logic signed [ITEM_W-1:0] item_sum;
	logic signed [BSUM_W-1:0] block_sum_q, bsum_next, bsum_q;
	logic [HALF_W-1:0] wh_q, ah_q;
	logic row_end_q;

	always_comb begin
		logic signed [NIB_W-1:0] w;
		logic signed [ACT_W-1:0] a;
		logic signed [PROD_W-1:0] p;
		item_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			w = s_axis_tdata[NIB_OFS + NIB_W*i +: NIB_W];
			a = s_axis_tdata[ACT_OFS + ACT_W*i +: ACT_W];
			p = $signed({{ACT_W{w[NIB_W-1]}}, w}) * $signed({{NIB_W{a[ACT_W-1]}}, a});
			item_sum = item_sum + {{(ITEM_W-PROD_W){p[PROD_W-1]}}, p};
		end
	end

	assign bsum_next = block_sum_q + {{(BSUM_W-ITEM_W){item_sum[ITEM_W-1]}}, item_sum};

	// scale decode and special cases
	logic [31:0] acc_q, res_q;
	logic [4:0] wex, aex;
	logic [9:0] wf, af;
	logic [10:0] wm, am;
	logic signed [EXP_W-1:0] we, ae, pe;
	logic wnan, anan, winf, ainf, wz, az, bz, tz, bneg, ts;
	logic [7:0] acc_e;
	logic [22:0] acc_f;
	logic acc_s, acc_nf, acc_z;
	logic spec;
	logic [31:0] specv;

	assign wex = wh_q[14:10];
	assign wf = wh_q[9:0];
	assign aex = ah_q[14:10];
	assign af = ah_q[9:0];
	assign wm = {(wex != 5'd0), wf};
	assign am = {(aex != 5'd0), af};
	assign we = (wex == 5'd0) ? -EXP_W'(24) : EXP_W'(wex) - EXP_W'(25);
	assign ae = (aex == 5'd0) ? -EXP_W'(24) : EXP_W'(aex) - EXP_W'(25);
	assign pe = we + ae;
	assign wnan = (wex == 5'h1F) && (wf != 10'd0);
	assign anan = (aex == 5'h1F) && (af != 10'd0);
	assign winf = (wex == 5'h1F) && (wf == 10'd0);
	assign ainf = (aex == 5'h1F) && (af == 10'd0);
	assign wz = (wex == 5'd0) && (wf == 10'd0);
	assign az = (aex == 5'd0) && (af == 10'd0);
	assign bz = (bsum_q == '0);
	assign tz = bz || wz || az;
	assign bneg = bsum_q[BSUM_W-1];
	assign ts = wh_q[15] ^ ah_q[15] ^ bneg;
	assign acc_e = acc_q[30:23];
	assign acc_f = acc_q[22:0];
	assign acc_s = acc_q[31];
	assign acc_nf = (acc_e == 8'hFF);
	assign acc_z = (acc_e == 8'd0) && (acc_f == 23'd0);

	always_comb begin
		spec = 1'b1;
		specv = QNAN_BITS;
		if (wnan || anan) begin
			specv = QNAN_BITS;
		end else if (winf || ainf) begin
			if (wz || az || bz) specv = QNAN_BITS;
			else if (acc_nf) begin
				if (acc_f != 23'd0 || ts != acc_s) specv = QNAN_BITS;
				else specv = acc_q;
			end else specv = {ts, INF_BITS[30:0]};
		end else if (acc_nf) begin
			specv = (acc_f != 23'd0) ? QNAN_BITS : acc_q;
		end else if (tz && acc_z) begin
			specv = {ts && acc_s, 31'd0};
		end else begin
			spec = 1'b0;
		end
	end

	// product of scales, then term magnitude
	logic [21:0] pm_q;
	logic signed [EXP_W-1:0] pe_q;
	logic ts_q;
	logic [BSUM_W-1:0] absb;
	logic [38:0] tprod;

	assign absb = bneg ? BSUM_W'(-bsum_q) : BSUM_W'(bsum_q);
	assign tprod = absb * pm_q;

	// operand registers
	logic [MAN_W-1:0] tm_q, am_q, sm_q;
	logic signed [EXP_W-1:0] te_q, ae_q, se_q;
	logic as_q, ss_q;

	// shared normalizer
	logic [MAN_W-1:0] nm_cur, nm_nxt;
	logic signed [EXP_W-1:0] ne_cur, ne_nxt;
	logic [5:0] tgt;
	logic n_done, n_step8;

	always_comb begin
		unique case (cmd.norm_sel)
			NORM_ACC: begin
				nm_cur = am_q;
				ne_cur = ae_q;
				tgt = 6'd61;
			end
			NORM_SUM: begin
				nm_cur = sm_q;
				ne_cur = se_q;
				tgt = 6'd62;
			end
			default: begin
				nm_cur = tm_q;
				ne_cur = te_q;
				tgt = 6'd61;
			end
		endcase
		n_done = (nm_cur == '0) || nm_cur[tgt];
		n_step8 = (nm_cur[tgt -: 8] == 8'd0);
		nm_nxt = n_step8 ? (nm_cur << 8) : (nm_cur << 1);
		ne_nxt = n_step8 ? (ne_cur - EXP_W'(8)) : (ne_cur - EXP_W'(1));
	end

	// alignment and add
	logic [MAN_W-1:0] m1, m2, m2s, lost_mask, al_m;
	logic signed [EXP_W-1:0] e1, e2, d, al_e;
	logic s1, s2, al_s;

	always_comb begin
		if (te_q >= ae_q) begin
			m1 = tm_q; e1 = te_q; s1 = ts_q;
			m2 = am_q; e2 = ae_q; s2 = as_q;
		end else begin
			m1 = am_q; e1 = ae_q; s1 = as_q;
			m2 = tm_q; e2 = te_q; s2 = ts_q;
		end
		d = e1 - e2;
		lost_mask = (MAN_W'(1) << d[5:0]) - MAN_W'(1);
		if (d >= EXP_W'(63)) m2s = MAN_W'(1);
		else m2s = (m2 >> d[5:0]) | MAN_W'((m2 & lost_mask) != '0);
		al_e = e1;
		if (tm_q == '0) begin
			al_m = am_q; al_e = ae_q; al_s = as_q;
		end else if (am_q == '0) begin
			al_m = tm_q; al_e = te_q; al_s = ts_q;
		end else if (s1 == s2) begin
			al_m = m1 + m2s; al_s = s1;
		end else if (m1 >= m2s) begin
			al_m = m1 - m2s; al_s = s1;
		end else begin
			al_m = m2s - m1; al_s = s2;
		end
	end

	// rounding to fp32, sum normalized with its top bit at 62
	logic signed [EXP_W-1:0] lim, sh, ex, biased;
	logic [MAN_W-1:0] qw, rmask, rem, half;
	logic [24:0] q25;
	logic [23:0] qf;
	logic rup;
	logic [31:0] rnd_val;

	always_comb begin
		lim = -EXP_W'(149) - se_q;
		sh = (lim > EXP_W'(39)) ? lim : EXP_W'(39);
		qw = sm_q >> sh[5:0];
		rmask = (MAN_W'(1) << sh[5:0]) - MAN_W'(1);
		rem = sm_q & rmask;
		half = MAN_W'(1) << (sh[5:0] - 6'd1);
		rup = (rem > half) || ((rem == half) && qw[0]);
		q25 = qw[24:0] + 25'(rup);
		ex = se_q + sh;
		if (q25[24]) begin
			qf = q25[24:1];
			ex = ex + EXP_W'(1);
		end else begin
			qf = q25[23:0];
		end
		biased = ex + EXP_W'(150);
		if (sm_q == '0) rnd_val = 32'd0;
		else if (sh >= EXP_W'(64) || qf == 24'd0) rnd_val = {ss_q, 31'd0};
		else if (qf[23]) begin
			if (biased >= EXP_W'(255)) rnd_val = {ss_q, INF_BITS[30:0]};
			else rnd_val = {ss_q, biased[7:0], qf[22:0]};
		end else rnd_val = {ss_q, 8'd0, qf[22:0]};
	end

	// output register
	logic out_v_q;
	logic [OUT_W-1:0] out_d_q;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_d_q;

	assign sts.spec = spec;
	assign sts.norm_done = n_done;
	assign sts.row_end = row_end_q;
	assign sts.out_busy = out_v_q && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= '0;
			acc_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.item_take) block_sum_q <= cmd.blk_end ? '0 : bsum_next;
			if (cmd.fin) acc_q <= row_end_q ? 32'd0 : res_q;
			if (cmd.fin && row_end_q) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blk_end) begin
			bsum_q <= bsum_next;
			wh_q <= s_axis_tdata[WSC_OFS +: HALF_W];
			ah_q <= s_axis_tdata[ASC_OFS +: HALF_W];
			row_end_q <= s_axis_tlast;
		end
		if (cmd.mul1) begin
			pm_q <= wm * am;
			pe_q <= pe;
			ts_q <= ts;
			if (spec) res_q <= specv;
		end
		if (cmd.mul2) begin
			tm_q <= {{(MAN_W-39){1'b0}}, tprod};
			te_q <= pe_q;
			am_q <= {{(MAN_W-24){1'b0}}, (acc_e != 8'd0), acc_f};
			ae_q <= (acc_e == 8'd0) ? -EXP_W'(149) : EXP_W'(acc_e) - EXP_W'(150);
			as_q <= acc_s;
		end
		if (cmd.norm_en && !n_done) begin
			unique case (cmd.norm_sel)
				NORM_ACC: begin
					am_q <= nm_nxt;
					ae_q <= ne_nxt;
				end
				NORM_SUM: begin
					sm_q <= nm_nxt;
					se_q <= ne_nxt;
				end
				default: begin
					tm_q <= nm_nxt;
					te_q <= ne_nxt;
				end
			endcase
		end
		if (cmd.align) begin
			sm_q <= al_m;
			se_q <= al_e;
			ss_q <= al_s;
		end
		if (cmd.rnd) res_q <= rnd_val;
		if (cmd.fin && row_end_q) out_d_q <= res_q;
	end
endmodule

@@ rtl/q4_q8_block_dot_accumulate.sv @@
// Top level: q4 x q8 block dot product with fp32 accumulator.
// Depends on qqdot_pkg, qqdot_ctrl, qqdot_dp.
//
// channel   dir  tdata (low bit up)                                  tlast
// s_axis    in   weight_nibbles, act_bytes, weight_scale_half,        row_end
//                act_scale_half (128 bits)
// m_axis    out  dot_result (32 bits)                                -
//
// Items 1 to 3 of a block are taken without a stall. The fourth item starts the float
// update in one shared normalizer and round unit: a NaN, infinity or zero result goes
// from the first multiply straight to finish, otherwise the multiplies, normalize
// passes on term and accumulator, align/add, a normalize pass on the sum, round, finish.
// Input stalls while the update runs or while a finished row result waits.
// arst_n clears the block sum, item count, accumulator and output valid.
module q4_q8_block_dot_accumulate (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [qqdot_pkg::IN_W-1:0] s_axis_tdata, // weight_nibbles, act_bytes, wscale, ascale
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [qqdot_pkg::OUT_W-1:0] m_axis_tdata // dot_result
);
	import qqdot_pkg::*;

	qqdot_cmd_t cmd;
	qqdot_sts_t sts;

	qqdot_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.cmd(cmd),
		.sts(sts)
	);

	qqdot_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cmd(cmd),
		.sts(sts)
	);
endmodule

@@ rtl/qqdot_chk.sv @@
// Port-level checker for the q4 x q8 block dot unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module qqdot_chk (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	logic [1:0] cnt_q;
	logic s_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (s_xfer) cnt_q <= cnt_q + 2'd1;
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_NEXT(a_quarter_ready, clk, arst_n, s_xfer && (cnt_q != 2'd3), s_axis_tready)
	`ASSERT_NEXT(a_block_busy, clk, arst_n, s_xfer && (cnt_q == 2'd3), !s_axis_tready)
endmodule

bind q4_q8_block_dot_accumulate qqdot_chk u_chk (.*);
